// ===== rtl/mci_pkg.sv =====
// ----------------------------------------------------------------------------
// mci_pkg
// Shared constants and controller/datapath command and status types for the
// 4x4 matrix inverse block.
// ----------------------------------------------------------------------------
package mci_pkg;

   localparam int ELEMENT_WIDTH_DEFAULT = 32;
   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int INDEX_WIDTH           = 4;
   localparam int MATRIX_ENTRIES        = 16;

   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = 4'd15;

   // MAC operand source
   localparam logic [1:0] OPSRC_ELEM = 2'd0;
   localparam logic [1:0] OPSRC_Q    = 2'd1;
   localparam logic [1:0] OPSRC_COF  = 2'd2;

   typedef struct packed {
      logic                   mat_wr;
      logic [INDEX_WIDTH-1:0] mat_addr;
      logic                   ld_mult;
      logic                   mac_start;
      logic [1:0]             op_src;
      logic                   mac_to_p;
      logic                   mac_clear;
      logic                   mac_sub;
      logic [INDEX_WIDTH-1:0] cof_addr;
      logic                   cof_wr;
      logic                   det_ld;
      logic                   div_start;
      logic                   out_load;
      logic [INDEX_WIDTH-1:0] out_index;
   } mci_cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic div_busy;
   } mci_stat_type;

endpackage

// ===== rtl/mci_req_if.sv =====
// ----------------------------------------------------------------------------
// mci_req_if
// Element input channel: valid/ready with one matrix element per transaction.
// ----------------------------------------------------------------------------
interface mci_req_if #(
   parameter int ELEMENT_WIDTH = mci_pkg::ELEMENT_WIDTH_DEFAULT
) ();
   logic                     valid;
   logic                     ready;
   logic [ELEMENT_WIDTH-1:0] element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

// ===== rtl/mci_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mci_rsp_if
// Result channel: valid/ready with one inverse element per transaction.
// ----------------------------------------------------------------------------
interface mci_rsp_if #(
   parameter int ELEMENT_WIDTH = mci_pkg::ELEMENT_WIDTH_DEFAULT
) ();
   logic                                valid;
   logic                                ready;
   logic [ELEMENT_WIDTH-1:0]            inverse_value;
   logic [mci_pkg::INDEX_WIDTH-1:0]     element_index;
   logic                                last_element;
   logic [ELEMENT_WIDTH-1:0]            determinant_value;
   logic                                singular;

   modport source (output valid, output inverse_value, output element_index,
                   output last_element, output determinant_value, output singular,
                   input ready);
   modport sink   (input valid, input inverse_value, input element_index,
                   input last_element, input determinant_value, input singular,
                   output ready);
endinterface

// ===== rtl/mci_dpath.sv =====
// ----------------------------------------------------------------------------
// mci_dpath
// Datapath: element and cofactor stores, bit-serial multiply-accumulate,
// determinant rounding, restoring divider and the result register.
// ----------------------------------------------------------------------------
module mci_dpath #(
   parameter int ELEMENT_WIDTH = mci_pkg::ELEMENT_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = mci_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mci_pkg::mci_cmd_type             cmd,
   output mci_pkg::mci_stat_type            stat,
   input  logic [ELEMENT_WIDTH-1:0]         element_value,
   output logic [ELEMENT_WIDTH-1:0]         inverse_value,
   output logic [mci_pkg::INDEX_WIDTH-1:0]  element_index,
   output logic                             last_element,
   output logic [ELEMENT_WIDTH-1:0]         determinant_value,
   output logic                             singular
);
   import mci_pkg::*;

   localparam int EW  = ELEMENT_WIDTH;
   localparam int FB  = FRACTION_BITS;
   localparam int WQ  = 2*EW + 2;          // 2x2 minor
   localparam int WC  = 3*EW + 1;          // cofactor
   localparam int WM  = 4*EW + 3;          // MAC accumulator
   localparam int WDM = 4*EW + 1;          // determinant magnitude
   localparam int WD  = (5*EW + 3 > 3*EW + 2*FB + 2) ? 5*EW + 3 : 3*EW + 2*FB + 2;
   localparam int WR  = (WM + 1 > 3*FB + 2) ? WM + 1 : 3*FB + 2;
   localparam int CW  = $clog2(EW);
   localparam int DW  = $clog2(EW + 1);

   // stores
   logic [EW-1:0] mat_mem [MATRIX_ENTRIES];
   logic [WC-1:0] cof_mem [MATRIX_ENTRIES];
   logic [EW-1:0] mat_rd;
   logic [WC-1:0] cof_rd;

   assign mat_rd = mat_mem[cmd.mat_addr];
   assign cof_rd = cof_mem[cmd.cof_addr];

   // MAC
   logic [EW-1:0] m_ff;
   logic [WM-1:0] op_ff, acc_ff, p_ff;
   logic [WQ-1:0] q_ff;
   logic [CW-1:0] mac_cnt_ff;
   logic          mac_busy_ff, to_p_ff, sub_ff;
   logic [WM-1:0] op_sel, acc_init, addend, acc_in;
   logic          mac_neg, mac_last;

   always_comb begin
      unique case (cmd.op_src)
         OPSRC_ELEM: op_sel = {{(WM-EW){mat_rd[EW-1]}}, mat_rd};
         OPSRC_Q:    op_sel = {{(WM-WQ){q_ff[WQ-1]}}, q_ff};
         OPSRC_COF:  op_sel = {{(WM-WC){cof_rd[WC-1]}}, cof_rd};
         default:    op_sel = '0;
      endcase
      if (cmd.mac_clear) acc_init = '0;
      else if (cmd.mac_to_p) acc_init = p_ff;
      else acc_init = {{(WM-WQ){q_ff[WQ-1]}}, q_ff};
   end

   // two's complement multiplier: the top bit carries negative weight
   assign mac_last = (mac_cnt_ff == CW'(EW - 1));
   assign mac_neg  = sub_ff ^ mac_last;
   assign addend   = mac_neg ? ~op_ff : op_ff;
   assign acc_in   = m_ff[0] ? acc_ff + addend + WM'(mac_neg) : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_busy_ff <= 1'b0;
      end else if (cmd.mac_start) begin
         mac_busy_ff <= 1'b1;
      end else if (mac_busy_ff && mac_last) begin
         mac_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mat_wr) mat_mem[cmd.mat_addr] <= element_value;
      if (cmd.cof_wr) cof_mem[cmd.cof_addr] <= p_ff[WC-1:0];
      if (cmd.ld_mult) m_ff <= mat_rd;
      if (cmd.mac_start) begin
         op_ff      <= op_sel;
         acc_ff     <= acc_init;
         mac_cnt_ff <= '0;
         to_p_ff    <= cmd.mac_to_p;
         sub_ff     <= cmd.mac_sub;
      end else if (mac_busy_ff) begin
         m_ff       <= m_ff >> 1;
         op_ff      <= op_ff << 1;
         acc_ff     <= acc_in;
         mac_cnt_ff <= mac_cnt_ff + CW'(1);
         if (mac_last) begin
            if (to_p_ff) p_ff <= acc_in;
            else q_ff <= acc_in[WQ-1:0];
         end
      end
   end

   // determinant
   logic [WDM-1:0] det_mag_ff;
   logic           det_neg_ff, det_zero_ff;
   logic [EW-1:0]  det_q_ff;
   logic [WM-1:0]  p_abs;
   logic [WR-1:0]  det_rnd, det_sh, det_lim, det_sat;

   assign p_abs = p_ff[WM-1] ? -p_ff : p_ff;

   always_comb begin
      det_rnd = WR'(det_mag_ff) + (WR'(1) << (3*FB - 1));
      det_sh  = det_rnd >> (3*FB);
      det_lim = det_neg_ff ? (WR'(1) << (EW - 1)) : (WR'(1) << (EW - 1)) - WR'(1);
      det_sat = (det_sh > det_lim) ? det_lim : det_sh;
   end

   always_ff @(posedge clock) begin
      if (cmd.det_ld) begin
         det_neg_ff  <= p_ff[WM-1];
         det_zero_ff <= (p_ff == '0);
         det_mag_ff  <= p_abs[WDM-1:0];
      end
      if (det_zero_ff) det_q_ff <= '0;
      else det_q_ff <= det_neg_ff ? -det_sat[EW-1:0] : det_sat[EW-1:0];
   end

   // restoring divider: floor(2|cof|*2^2F / |det|), one quotient bit a cycle
   logic [WD-1:0] rem_ff, dsh_ff;
   logic [EW:0]   quo_ff;
   logic [DW-1:0] div_cnt_ff;
   logic          div_busy_ff, first_ff, ovf_ff, div_neg_ff;
   logic [WC-1:0] cof_abs;
   logic          rem_ge;

   assign cof_abs = cof_rd[WC-1] ? -cof_rd : cof_rd;
   assign rem_ge  = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && !first_ff && div_cnt_ff == '0) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff     <= WD'(cof_abs) << (2*FB + 1);
         dsh_ff     <= WD'(det_mag_ff) << (EW + 1);
         quo_ff     <= '0;
         first_ff   <= 1'b1;
         div_cnt_ff <= DW'(EW);
         div_neg_ff <= cof_rd[WC-1] ^ det_neg_ff;
      end else if (div_busy_ff) begin
         dsh_ff <= dsh_ff >> 1;
         if (first_ff) begin
            ovf_ff   <= rem_ge;
            first_ff <= 1'b0;
         end else begin
            if (rem_ge) rem_ff <= rem_ff - dsh_ff;
            quo_ff     <= {quo_ff[EW-1:0], rem_ge};
            div_cnt_ff <= div_cnt_ff - DW'(1);
         end
      end
   end

   // round half away from zero, then saturate
   logic [EW+1:0] quo_inc;
   logic [EW:0]   quo_rnd, inv_lim, inv_sat;
   logic [EW-1:0] inv_val;

   always_comb begin
      quo_inc = {1'b0, quo_ff} + (EW+2)'(1);
      quo_rnd = quo_inc[EW+1:1];
      inv_lim = div_neg_ff ? ((EW+1)'(1) << (EW - 1)) : ((EW+1)'(1) << (EW - 1)) - (EW+1)'(1);
      inv_sat = (ovf_ff || quo_rnd > inv_lim) ? inv_lim : quo_rnd;
      if (det_zero_ff) inv_val = '0;
      else inv_val = div_neg_ff ? -inv_sat[EW-1:0] : inv_sat[EW-1:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         inverse_value     <= inv_val;
         element_index     <= cmd.out_index;
         last_element      <= (cmd.out_index == LAST_INDEX);
         determinant_value <= det_q_ff;
         singular          <= det_zero_ff;
      end
   end

   assign stat.mac_busy = mac_busy_ff;
   assign stat.div_busy = div_busy_ff;

endmodule

// ===== rtl/mci_ctrl.sv =====
// ----------------------------------------------------------------------------
// mci_ctrl
// Sequencer: load, cofactor expansion, determinant, division and result
// handshake. Drives the datapath through mci_cmd_type.
// ----------------------------------------------------------------------------
module mci_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mci_pkg::mci_stat_type stat,
   output mci_pkg::mci_cmd_type  cmd
);
   import mci_pkg::*;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_CF_M  = 4'd1;
   localparam logic [3:0] S_CF_S  = 4'd2;
   localparam logic [3:0] S_CF_W  = 4'd3;
   localparam logic [3:0] S_CF_WR = 4'd4;
   localparam logic [3:0] S_DT_M  = 4'd5;
   localparam logic [3:0] S_DT_S  = 4'd6;
   localparam logic [3:0] S_DT_W  = 4'd7;
   localparam logic [3:0] S_DT_LD = 4'd8;
   localparam logic [3:0] S_DV_S  = 4'd9;
   localparam logic [3:0] S_DV_W  = 4'd10;

   // products of one 3x3 expansion term
   localparam logic [1:0] PROD_PLUS  = 2'd0;
   localparam logic [1:0] PROD_MINUS = 2'd1;
   localparam logic [1:0] PROD_OUTER = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [3:0] load_cnt_ff, load_cnt_in;
   logic [3:0] k_ff, k_in;
   logic [1:0] term_ff, term_in;
   logic [1:0] prod_ff, prod_in;
   logic       rsp_valid_ff, rsp_valid_in;

   function automatic logic [1:0] skip(input logic [1:0] n, input logic [1:0] x);
      return (n >= x) ? n + 2'd1 : n;
   endfunction

   function automatic logic [1:0] cyc(input logic [1:0] t);
      return (t == 2'd2) ? 2'd0 : t + 2'd1;
   endfunction

   logic [1:0] r, c, tj, tk;
   logic [1:0] m_row, m_col, o_row, o_col;
   logic       out_free;

   assign r        = k_ff[3:2];
   assign c        = k_ff[1:0];
   assign tj       = cyc(term_ff);
   assign tk       = cyc(tj);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // minor rows/cols 0..2 map to matrix rows/cols skipping r and c
   always_comb begin
      unique case (prod_ff)
         PROD_PLUS: begin
            m_row = 2'd2; m_col = tk; o_row = 2'd1; o_col = tj;
         end
         PROD_MINUS: begin
            m_row = 2'd2; m_col = tj; o_row = 2'd1; o_col = tk;
         end
         PROD_OUTER: begin
            m_row = 2'd0; m_col = term_ff; o_row = 2'd0; o_col = 2'd0;
         end
         default: begin
            m_row = 2'd0; m_col = 2'd0; o_row = 2'd0; o_col = 2'd0;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      k_in         = k_ff;
      term_in      = term_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            req_ready    = 1'b1;
            cmd.mat_addr = load_cnt_ff;
            if (req_valid) begin
               cmd.mat_wr  = 1'b1;
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == LAST_INDEX) state_in = S_CF_M;
            end
         end
         S_CF_M: begin
            cmd.mat_addr = {skip(m_row, r), skip(m_col, c)};
            cmd.ld_mult  = 1'b1;
            state_in     = S_CF_S;
         end
         S_CF_S: begin
            cmd.mat_addr  = {skip(o_row, r), skip(o_col, c)};
            cmd.mac_start = 1'b1;
            if (prod_ff == PROD_OUTER) begin
               cmd.op_src    = OPSRC_Q;
               cmd.mac_to_p  = 1'b1;
               cmd.mac_clear = (term_ff == 2'd0);
               cmd.mac_sub   = r[0] ^ c[0];
            end else begin
               cmd.op_src    = OPSRC_ELEM;
               cmd.mac_clear = (prod_ff == PROD_PLUS);
               cmd.mac_sub   = (prod_ff == PROD_MINUS);
            end
            state_in = S_CF_W;
         end
         S_CF_W: begin
            if (!stat.mac_busy) begin
               if (prod_ff != PROD_OUTER) begin
                  prod_in  = prod_ff + 2'd1;
                  state_in = S_CF_M;
               end else begin
                  prod_in = PROD_PLUS;
                  if (term_ff != 2'd2) begin
                     term_in  = term_ff + 2'd1;
                     state_in = S_CF_M;
                  end else begin
                     term_in  = 2'd0;
                     state_in = S_CF_WR;
                  end
               end
            end
         end
         S_CF_WR: begin
            cmd.cof_addr = k_ff;
            cmd.cof_wr   = 1'b1;
            k_in         = k_ff + 4'd1;
            state_in     = (k_ff == LAST_INDEX) ? S_DT_M : S_CF_M;
         end
         S_DT_M: begin
            cmd.mat_addr = {2'd0, k_ff[1:0]};
            cmd.ld_mult  = 1'b1;
            state_in     = S_DT_S;
         end
         S_DT_S: begin
            cmd.cof_addr  = k_ff;
            cmd.op_src    = OPSRC_COF;
            cmd.mac_start = 1'b1;
            cmd.mac_to_p  = 1'b1;
            cmd.mac_clear = (k_ff == 4'd0);
            state_in      = S_DT_W;
         end
         S_DT_W: begin
            if (!stat.mac_busy) begin
               if (k_ff == 4'd3) begin
                  k_in     = 4'd0;
                  state_in = S_DT_LD;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_DT_M;
               end
            end
         end
         S_DT_LD: begin
            cmd.det_ld = 1'b1;
            state_in   = S_DV_S;
         end
         S_DV_S: begin
            // adjugate: transposed cofactor
            cmd.cof_addr  = {k_ff[1:0], k_ff[3:2]};
            cmd.div_start = 1'b1;
            state_in      = S_DV_W;
         end
         S_DV_W: begin
            cmd.out_index = k_ff;
            if (!stat.div_busy && out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               k_in         = k_ff + 4'd1;
               state_in     = (k_ff == LAST_INDEX) ? S_LOAD : S_DV_S;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_cnt_ff  <= '0;
         k_ff         <= '0;
         term_ff      <= '0;
         prod_ff      <= PROD_PLUS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         k_ff         <= k_in;
         term_ff      <= term_in;
         prod_ff      <= prod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/matrix4x4_cofactor_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_cofactor_inverse
// 4x4 fixed-point matrix inverse by the adjugate over the determinant.
// ----------------------------------------------------------------------------
// Send 16 signed Q-format elements in row-major order, one per transaction;
// ready stays high throughout the load. After the sixteenth the block stops
// taking elements, forms all 16 cofactors and the determinant exactly with
// one bit-serial multiply-accumulate unit (148 products), then runs a
// restoring divider once per result and returns the 16 inverse elements in
// row-major order with index, last flag, determinant and singular flag.
// Results round to nearest (ties away from zero) and saturate; a zero
// determinant gives singular=1 and zero values. Loading of the next matrix
// starts as soon as the last result is in the output register.
// ----------------------------------------------------------------------------
module matrix4x4_cofactor_inverse #(
   parameter int ELEMENT_WIDTH = mci_pkg::ELEMENT_WIDTH_DEFAULT,
   parameter int FRACTION_BITS = mci_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mci_req_if.sink    req_chan,
   mci_rsp_if.source  rsp_chan
);
   import mci_pkg::*;

   mci_cmd_type  cmd;
   mci_stat_type stat;

   mci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mci_dpath #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .element_value     (req_chan.element_value),
      .inverse_value     (rsp_chan.inverse_value),
      .element_index     (rsp_chan.element_index),
      .last_element      (rsp_chan.last_element),
      .determinant_value (rsp_chan.determinant_value),
      .singular          (rsp_chan.singular)
   );

   // elements are taken only while the arithmetic units are quiet
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> (!stat.mac_busy && !stat.div_busy))
      else $error("element accepted while arithmetic busy");

   a_mac_start: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_start |-> !stat.mac_busy)
      else $error("multiply restarted while busy");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (!stat.div_busy && !stat.mac_busy))
      else $error("divide restarted while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("pending result overwritten");

endmodule
